/* sv/sss_pkg.sv */
package sss_pkg;

    localparam int SEQ_LEN    = 31;
    localparam int NUM_SC     = 2 * SEQ_LEN;
    localparam int NUM_GROUPS = 168;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 6;
    localparam int STEP_W     = 5;
    localparam int ACC_W      = 6;
    localparam int PEAK_W     = 5;
    localparam int SHIFT_W    = 5;
    localparam int GROUP_W    = 8;
    localparam int CELL_W     = 9;
    localparam int SECTOR_W   = 2;
    localparam int THRESH_W   = 5;
    localparam int CFG_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd31;
    localparam logic [5:0]          ODD_C_OFFSET = 6'd3;

    localparam logic REG_SECTOR = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    localparam logic [3:0] TAPS_S = 4'b0010;
    localparam logic [3:0] TAPS_C = 4'b0100;
    localparam logic [3:0] TAPS_Z = 4'b1011;

    typedef enum logic [1:0] {
        SIGN_ZERO  = 2'd0,
        SIGN_PLUS  = 2'd1,
        SIGN_MINUS = 2'd3
    } sign_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_WEAK  = 2'd1,
        STATUS_MISS  = 2'd2
    } status_t;

    // One queue word: the sign of a subcarrier and a flag on the last one of a symbol.
    typedef struct packed {
        logic  last;
        sign_t code;
    } word_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector_id;
        logic [THRESH_W-1:0] match_threshold;
    } cfg_t;

    typedef struct packed {
        logic               found;
        logic [GROUP_W-1:0] group;
    } lookup_t;

    function automatic logic [SEQ_LEN-1:0] build_mseq(input logic [3:0] taps);
        logic [SEQ_LEN-1:0] x;
        logic               b;
        x    = '0;
        x[4] = 1'b1;
        for (int i = 0; i + 5 < SEQ_LEN; i++)
        begin
            b = x[i];
            if (taps[0]) b = b ^ x[i + 1];
            if (taps[1]) b = b ^ x[i + 2];
            if (taps[2]) b = b ^ x[i + 3];
            if (taps[3]) b = b ^ x[i + 4];
            x[i + 5] = b;
        end
        return x;
    endfunction

    localparam logic [SEQ_LEN-1:0] S_SEQ = build_mseq(TAPS_S);
    localparam logic [SEQ_LEN-1:0] C_SEQ = build_mseq(TAPS_C);
    localparam logic [SEQ_LEN-1:0] Z_SEQ = build_mseq(TAPS_Z);

    function automatic logic [4:0] mod31(input logic [5:0] v);
        return (v >= 6'(SEQ_LEN)) ? 5'(v - 6'(SEQ_LEN)) : v[4:0];
    endfunction

    // The pair table holds (m0, m1) with m1 - m0 = d and 31*(d-1) + m0 = m',
    // where m' skips a few values between groups; this inverts that mapping.
    function automatic lookup_t lookup_pair(input logic [4:0] lo, input logic [4:0] hi);
        logic [4:0] d;
        logic [2:0] dm1;
        logic [7:0] mp;
        lookup_t    r;
        d       = hi - lo;
        dm1     = 3'(d - 5'd1);
        mp      = {dm1, 5'b0} - {5'b0, dm1} + {3'b0, lo};
        r.found = 1'b0;
        r.group = '0;
        if (hi > lo && d <= 5'd7)
        begin
            case (mp) inside
                [8'd0:8'd29]:
                begin
                    r.found = 1'b1;
                    r.group = mp;
                end
                [8'd31:8'd59]:
                begin
                    r.found = 1'b1;
                    r.group = mp - 8'd1;
                end
                [8'd62:8'd89]:
                begin
                    r.found = 1'b1;
                    r.group = mp - 8'd3;
                end
                [8'd93:8'd119]:
                begin
                    r.found = 1'b1;
                    r.group = mp - 8'd6;
                end
                [8'd124:8'd149]:
                begin
                    r.found = 1'b1;
                    r.group = mp - 8'd10;
                end
                [8'd155:8'd179]:
                begin
                    r.found = 1'b1;
                    r.group = mp - 8'd15;
                end
                [8'd186:8'd188]:
                begin
                    r.found = 1'b1;
                    r.group = mp - 8'd21;
                end
                default:
                begin
                    r.found = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

/* sv/sss_front.sv */
module sss_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
    input  logic                           q_full,
    output logic                           q_push,
    output sss_pkg::word_t                 q_word
);
    import sss_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             last;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign last     = (count_reg == CNT_W'(NUM_SC - 1));

    always_comb
    begin
        q_word.last = last;
        if (sample == '0)
            q_word.code = SIGN_ZERO;
        else if (sample[SAMPLE_W-1])
            q_word.code = SIGN_MINUS;
        else
            q_word.code = SIGN_PLUS;
    end

    always_comb
    begin
        count_next = count_reg;
        if (q_push)
            count_next = last ? '0 : count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

/* sv/sss_fifo.sv */
module sss_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sss_pkg::word_t push_word,
    output logic           full,
    input  logic           pop,
    output sss_pkg::word_t pop_word,
    output logic           empty
);
    import sss_pkg::*;

    word_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (FIFO_AW + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (FIFO_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

/* sv/sss_back.sv */
module sss_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sss_pkg::cfg_t                  cfg,
    input  logic                           q_empty,
    input  sss_pkg::word_t                 q_word,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sss_pkg::STATUS_W-1:0]   status,
    output logic [sss_pkg::CELL_W-1:0]     cell_id,
    output logic                           second_half,
    output logic [sss_pkg::SHIFT_W-1:0]    shift_even,
    output logic [sss_pkg::SHIFT_W-1:0]    shift_odd,
    output logic [sss_pkg::PEAK_W-1:0]     peak_even,
    output logic [sss_pkg::PEAK_W-1:0]     peak_odd
);
    import sss_pkg::*;

    typedef enum logic [6:0] {
        ST_LOAD   = 7'b0000001,
        ST_CORR_E = 7'b0000010,
        ST_SRCH_E = 7'b0000100,
        ST_CORR_O = 7'b0001000,
        ST_SRCH_O = 7'b0010000,
        ST_LOOKUP = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    localparam logic signed [ACC_W-1:0] ACC_ONE   = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ACC_MINUS = -ACC_W'(1);

    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     parity_reg, parity_next;
    logic                     out_valid_reg, out_valid_next;

    sign_t                    ev_reg [SEQ_LEN];
    sign_t                    ev_next [SEQ_LEN];
    sign_t                    od_reg [SEQ_LEN];
    sign_t                    od_next [SEQ_LEN];
    logic signed [ACC_W-1:0]  acc_reg [SEQ_LEN];
    logic signed [ACC_W-1:0]  acc_next [SEQ_LEN];
    logic signed [ACC_W-1:0]  delta [SEQ_LEN];
    logic [SEQ_LEN-1:0]       s_rot_reg, s_rot_next;

    logic [PEAK_W-1:0]        best_peak_reg, best_peak_next;
    logic [SHIFT_W-1:0]       best_shift_reg, best_shift_next;
    logic [SHIFT_W-1:0]       m0_reg, m0_next, m1_reg, m1_next;
    logic [PEAK_W-1:0]        pe_reg, pe_next, po_reg, po_next;
    status_t                  status_reg, status_next;
    logic                     half_reg, half_next;
    logic [GROUP_W-1:0]       group_reg, group_next;

    status_t                  out_status_reg, out_status_next;
    logic [CELL_W-1:0]        out_cell_reg, out_cell_next;
    logic                     out_half_reg, out_half_next;
    logic [SHIFT_W-1:0]       out_m0_reg, out_m0_next, out_m1_reg, out_m1_next;
    logic [PEAK_W-1:0]        out_pe_reg, out_pe_next, out_po_reg, out_po_next;

    logic                     last_step;
    logic                     odd_half;
    sign_t                    elem;
    logic [4:0]               c_idx, z_idx;
    logic                     descr, nz, neg;
    logic signed [ACC_W-1:0]  cand;
    logic                     better;
    logic [PEAK_W-1:0]        cand_peak;
    logic [SHIFT_W-1:0]       cand_shift;
    logic                     peak_low, swap;
    logic [SHIFT_W-1:0]       lo, hi;
    lookup_t                  lk;
    logic [CELL_W-1:0]        cell_calc;

    assign last_step = (step_reg == STEP_W'(SEQ_LEN - 1));
    assign odd_half  = (state_reg == ST_CORR_O);
    assign elem      = odd_half ? od_reg[0] : ev_reg[0];
    assign c_idx     = mod31(6'(step_reg) + 6'(cfg.sector_id) + (odd_half ? ODD_C_OFFSET : 6'd0));
    assign z_idx     = mod31(6'(step_reg) + 6'(m0_reg[2:0]));
    assign descr     = C_SEQ[c_idx] ^ (odd_half & Z_SEQ[z_idx]);
    assign nz        = (elem != SIGN_ZERO);
    assign neg       = elem[1] ^ descr;

    always_comb
    begin
        for (int j = 0; j < SEQ_LEN; j++)
            delta[j] = !nz ? '0 : ((neg ^ s_rot_reg[j]) ? ACC_MINUS : ACC_ONE);
    end

    assign cand       = acc_reg[step_reg];
    assign better     = cand > $signed({1'b0, best_peak_reg});
    assign cand_peak  = better ? cand[PEAK_W-1:0] : best_peak_reg;
    assign cand_shift = better ? step_reg : best_shift_reg;

    assign peak_low = (pe_reg < cfg.match_threshold) || (po_reg < cfg.match_threshold);
    assign swap     = (m0_reg > m1_reg);
    assign lo       = swap ? m1_reg : m0_reg;
    assign hi       = swap ? m0_reg : m1_reg;
    assign lk       = lookup_pair(lo, hi);

    assign cell_calc = ({1'b0, group_reg} << 1) + {1'b0, group_reg} + CELL_W'(cfg.sector_id);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        parity_next     = parity_reg;
        out_valid_next  = out_valid_reg;
        ev_next         = ev_reg;
        od_next         = od_reg;
        acc_next        = acc_reg;
        s_rot_next      = s_rot_reg;
        best_peak_next  = best_peak_reg;
        best_shift_next = best_shift_reg;
        m0_next         = m0_reg;
        m1_next         = m1_reg;
        pe_next         = pe_reg;
        po_next         = po_reg;
        status_next     = status_reg;
        half_next       = half_reg;
        group_next      = group_reg;
        out_status_next = out_status_reg;
        out_cell_next   = out_cell_reg;
        out_half_next   = out_half_reg;
        out_m0_next     = out_m0_reg;
        out_m1_next     = out_m1_reg;
        out_pe_next     = out_pe_reg;
        out_po_next     = out_po_reg;
        q_pop           = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    parity_next = ~parity_reg;
                    if (parity_reg)
                    begin
                        for (int k = 0; k < SEQ_LEN - 1; k++)
                            od_next[k] = od_reg[k + 1];
                        od_next[SEQ_LEN-1] = q_word.code;
                    end
                    else
                    begin
                        for (int k = 0; k < SEQ_LEN - 1; k++)
                            ev_next[k] = ev_reg[k + 1];
                        ev_next[SEQ_LEN-1] = q_word.code;
                    end
                    if (q_word.last)
                    begin
                        parity_next = 1'b0;
                        step_next   = '0;
                        s_rot_next  = S_SEQ;
                        for (int j = 0; j < SEQ_LEN; j++)
                            acc_next[j] = '0;
                        state_next  = ST_CORR_E;
                    end
                end
            end
            ST_CORR_E, ST_CORR_O:
            begin
                for (int j = 0; j < SEQ_LEN; j++)
                    acc_next[j] = acc_reg[j] + delta[j];
                if (odd_half)
                begin
                    for (int k = 0; k < SEQ_LEN - 1; k++)
                        od_next[k] = od_reg[k + 1];
                    od_next[SEQ_LEN-1] = od_reg[0];
                end
                else
                begin
                    for (int k = 0; k < SEQ_LEN - 1; k++)
                        ev_next[k] = ev_reg[k + 1];
                    ev_next[SEQ_LEN-1] = ev_reg[0];
                end
                s_rot_next = {s_rot_reg[0], s_rot_reg[SEQ_LEN-1:1]};
                step_next  = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    step_next       = '0;
                    best_peak_next  = '0;
                    best_shift_next = '0;
                    state_next      = odd_half ? ST_SRCH_O : ST_SRCH_E;
                end
            end
            ST_SRCH_E:
            begin
                best_peak_next  = cand_peak;
                best_shift_next = cand_shift;
                step_next       = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    m0_next    = cand_shift;
                    pe_next    = cand_peak;
                    step_next  = '0;
                    s_rot_next = S_SEQ;
                    for (int j = 0; j < SEQ_LEN; j++)
                        acc_next[j] = '0;
                    state_next = ST_CORR_O;
                end
            end
            ST_SRCH_O:
            begin
                best_peak_next  = cand_peak;
                best_shift_next = cand_shift;
                step_next       = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    m1_next    = cand_shift;
                    po_next    = cand_peak;
                    step_next  = '0;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (peak_low)
                begin
                    status_next = STATUS_WEAK;
                    half_next   = 1'b0;
                    group_next  = '0;
                end
                else
                begin
                    status_next = lk.found ? STATUS_FOUND : STATUS_MISS;
                    half_next   = swap;
                    group_next  = lk.group;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_cell_next   = (status_reg == STATUS_FOUND) ? cell_calc : '0;
                    out_half_next   = half_reg;
                    out_m0_next     = m0_reg;
                    out_m1_next     = m1_reg;
                    out_pe_next     = pe_reg;
                    out_po_next     = po_reg;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            step_reg      <= '0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg         <= ev_next;
        od_reg         <= od_next;
        acc_reg        <= acc_next;
        s_rot_reg      <= s_rot_next;
        best_peak_reg  <= best_peak_next;
        best_shift_reg <= best_shift_next;
        m0_reg         <= m0_next;
        m1_reg         <= m1_next;
        pe_reg         <= pe_next;
        po_reg         <= po_next;
        status_reg     <= status_next;
        half_reg       <= half_next;
        group_reg      <= group_next;
        out_status_reg <= out_status_next;
        out_cell_reg   <= out_cell_next;
        out_half_reg   <= out_half_next;
        out_m0_reg     <= out_m0_next;
        out_m1_reg     <= out_m1_next;
        out_pe_reg     <= out_pe_next;
        out_po_reg     <= out_po_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign cell_id     = out_cell_reg;
    assign second_half = out_half_reg;
    assign shift_even  = out_m0_reg;
    assign shift_odd   = out_m1_reg;
    assign peak_even   = out_pe_reg;
    assign peak_odd    = out_po_reg;

endmodule

/* sv/sss_cell_id_detector.sv */
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  sample (16-bit signed subcarrier)
// output    out        out_valid/out_stall  status, cell_id, second_half, shifts, peaks
// config    in         cfg_write            cfg_index, cfg_data
//
// A symbol is 62 words; the front takes one word per cycle, unless the four-word queue
// is full. After the last word the back accumulates, then searches, each half in turn over
// 31 parallel shift accumulators, and then passes through a lookup state and an emit state.
// Reset is asynchronous; it clears control state and the sector and sets the threshold to 31,
// but leaves the data registers alone; no clearing pass is needed.
// A stalled result holds in the output register while the front keeps filling the queue.
module sss_cell_id_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sss_pkg::STATUS_W-1:0]        status,
    output logic [sss_pkg::CELL_W-1:0]          cell_id,
    output logic                                second_half,
    output logic [sss_pkg::SHIFT_W-1:0]         shift_even,
    output logic [sss_pkg::SHIFT_W-1:0]         shift_odd,
    output logic [sss_pkg::PEAK_W-1:0]          peak_even,
    output logic [sss_pkg::PEAK_W-1:0]          peak_odd,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [sss_pkg::CFG_W-1:0]           cfg_data
);
    import sss_pkg::*;

    logic [SECTOR_W-1:0] sector_reg;
    logic [THRESH_W-1:0] thresh_reg;
    cfg_t                cfg;
    logic                q_full, q_push, q_pop, q_empty;
    word_t               push_word, pop_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_reg <= '0;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SECTOR: sector_reg <= cfg_data[SECTOR_W-1:0];
                REG_THRESH: thresh_reg <= cfg_data[THRESH_W-1:0];
                default:    sector_reg <= sector_reg;
            endcase
        end
    end

    assign cfg.sector_id       = sector_reg;
    assign cfg.match_threshold = thresh_reg;

    sss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    sss_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (pop_word),
        .empty     (q_empty)
    );

    sss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_word      (pop_word),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cell_id     (cell_id),
        .second_half (second_half),
        .shift_even  (shift_even),
        .shift_odd   (shift_odd),
        .peak_even   (peak_even),
        .peak_odd    (peak_odd)
    );

endmodule

/* sv/sss_checker.sv */
module sss_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [sss_pkg::STATUS_W-1:0]        status,
    input  logic [sss_pkg::CELL_W-1:0]          cell_id,
    input  logic                                second_half,
    input  logic [sss_pkg::SHIFT_W-1:0]         shift_even,
    input  logic [sss_pkg::SHIFT_W-1:0]         shift_odd,
    input  logic [sss_pkg::PEAK_W-1:0]          peak_even,
    input  logic [sss_pkg::PEAK_W-1:0]          peak_odd
);
    import sss_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(sample))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(cell_id)
            && $stable(second_half) && $stable(shift_even) && $stable(shift_odd)
            && $stable(peak_even) && $stable(peak_odd))
        else $error("stalled result word changed");

    a_weak_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_WEAK |-> cell_id == '0 && !second_half)
        else $error("weak result carries a cell or a half flag");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shift_even != 5'd31 && shift_odd != 5'd31)
        else $error("shift outside the sequence");

    a_half_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_WEAK |-> second_half == (shift_even > shift_odd))
        else $error("half flag disagrees with shift order");

endmodule

bind sss_cell_id_detector sss_checker u_sss_checker (.*);

/* tb/sv/sss_cell_id_detector_tb.sv */
`timescale 1ns / 100ps

module sss_cell_id_detector_tb;

    import sss_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_WORDS = 1200;
    localparam int MIN_SYMBOLS  = 16;

    typedef struct packed {
        status_t             status;
        logic [CELL_W-1:0]   cell_id;
        logic                second_half;
        logic [SHIFT_W-1:0]  shift_even;
        logic [SHIFT_W-1:0]  shift_odd;
        logic [PEAK_W-1:0]   peak_even;
        logic [PEAK_W-1:0]   peak_odd;
    } detection_t;

    class cell_id_tracker;
        bit         s_bits[SEQ_LEN];
        bit         c_bits[SEQ_LEN];
        bit         z_bits[SEQ_LEN];
        int         group_m0[NUM_GROUPS];
        int         group_m1[NUM_GROUPS];
        int         signs[NUM_SC];
        int         folded[SEQ_LEN];
        int         fill;
        int         sector;
        int         threshold;
        int         mismatches;
        detection_t pending_detections[$];

        function new();
            int qp;
            int q;
            int mp;
            foreach (s_bits[i])
            begin
                s_bits[i] = 1'b0;
                c_bits[i] = 1'b0;
                z_bits[i] = 1'b0;
            end
            s_bits[4] = 1'b1;
            c_bits[4] = 1'b1;
            z_bits[4] = 1'b1;
            for (int i = 0; i + 5 < SEQ_LEN; i++)
            begin
                s_bits[i + 5] = s_bits[i + 2] ^ s_bits[i];
                c_bits[i + 5] = c_bits[i + 3] ^ c_bits[i];
                z_bits[i + 5] = z_bits[i + 4] ^ z_bits[i + 2] ^ z_bits[i + 1] ^ z_bits[i];
            end
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                qp = g / 30;
                q  = (g + qp * (qp + 1) / 2) / 30;
                mp = g + q * (q + 1) / 2;
                group_m0[g] = mp % SEQ_LEN;
                group_m1[g] = (group_m0[g] + mp / SEQ_LEN + 1) % SEQ_LEN;
            end
            fill       = 0;
            sector     = 0;
            threshold  = int'(THRESH_RESET);
            mismatches = 0;
        endfunction

        function int pm(bit b);
            return b ? -1 : 1;
        endfunction

        function int peak_of(output int at);
            int top;
            int acc;
            top = 0;
            at  = 0;
            for (int j = 0; j < SEQ_LEN; j++)
            begin
                acc = 0;
                for (int i = 0; i < SEQ_LEN; i++)
                    acc += folded[i] * pm(s_bits[(i + j) % SEQ_LEN]);
                if (acc > top)
                begin
                    top = acc;
                    at  = j;
                end
            end
            return top;
        endfunction

        function void detect_cell();
            int         m0;
            int         m1;
            int         pk_e;
            int         pk_o;
            int         lo;
            int         hi;
            detection_t d;
            for (int i = 0; i < SEQ_LEN; i++)
                folded[i] = signs[2 * i] * pm(c_bits[(i + sector) % SEQ_LEN]);
            pk_e = peak_of(m0);
            for (int i = 0; i < SEQ_LEN; i++)
                folded[i] = signs[2 * i + 1] * pm(c_bits[(i + sector + 3) % SEQ_LEN])
                            * pm(z_bits[(i + m0 % 8) % SEQ_LEN]);
            pk_o = peak_of(m1);
            d            = '0;
            d.status     = STATUS_WEAK;
            d.shift_even = SHIFT_W'(m0);
            d.shift_odd  = SHIFT_W'(m1);
            d.peak_even  = PEAK_W'(pk_e);
            d.peak_odd   = PEAK_W'(pk_o);
            if (pk_e >= threshold && pk_o >= threshold)
            begin
                lo            = (m0 < m1) ? m0 : m1;
                hi            = (m0 < m1) ? m1 : m0;
                d.second_half = (m0 > m1);
                d.status      = STATUS_MISS;
                for (int g = 0; g < NUM_GROUPS; g++)
                begin
                    if (d.status == STATUS_MISS && group_m0[g] == lo && group_m1[g] == hi)
                    begin
                        d.status  = STATUS_FOUND;
                        d.cell_id = CELL_W'(3 * g + sector);
                    end
                end
            end
            pending_detections.push_back(d);
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] value);
            signs[fill] = (value == '0) ? 0 : (value[SAMPLE_W-1] ? -1 : 1);
            fill++;
            if (fill == NUM_SC)
            begin
                fill = 0;
                detect_cell();
            end
        endfunction

        function void compare_field(string label, int want, int seen);
            if (want != seen)
            begin
                $display("%0t ns: %s expected %0d, actual %0d", $time, label, want, seen);
                mismatches++;
            end
        endfunction

        function void check_detection(detection_t got);
            detection_t want;
            if (pending_detections.size() == 0)
            begin
                $display("%0t ns: result word with nothing expected, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_detections.pop_front();
            compare_field("status", int'(want.status), int'(got.status));
            compare_field("cell_id", want.cell_id, got.cell_id);
            compare_field("second_half", want.second_half, got.second_half);
            compare_field("shift_even", want.shift_even, got.shift_even);
            compare_field("shift_odd", want.shift_odd, got.shift_odd);
            compare_field("peak_even", want.peak_even, got.peak_even);
            compare_field("peak_odd", want.peak_odd, got.peak_odd);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic [STATUS_W-1:0]        status;
    logic [CELL_W-1:0]          cell_id;
    logic                       second_half;
    logic [SHIFT_W-1:0]         shift_even;
    logic [SHIFT_W-1:0]         shift_odd;
    logic [PEAK_W-1:0]          peak_even;
    logic [PEAK_W-1:0]          peak_odd;
    logic                       cfg_write;
    logic                       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    cell_id_tracker tracker;
    int             plan[NUM_SC];
    int             words_sent    = 0;
    int             symbols_sent  = 0;
    int             cycle_count   = 0;
    bit             calm          = 1'b0;

    sss_cell_id_detector u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cell_id     (cell_id),
        .second_half (second_half),
        .shift_even  (shift_even),
        .shift_odd   (shift_odd),
        .peak_even   (peak_even),
        .peak_odd    (peak_odd),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("sss_cell_id_detector verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_detection({status, cell_id, second_half, shift_even, shift_odd,
                                     peak_even, peak_odd});
    end

    initial
    begin : stall_gen
        int hold;
        int run;
        hold      = 0;
        run       = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                out_stall <= 1'b0;
            else if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (run > 0)
                    run--;
                else if ($urandom_range(0, 1) == 1)
                    hold = $urandom_range(1, 13);
                else
                    run = $urandom_range(1, 40);
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] word_for(int sg);
        if (sg == 0)
            return '0;
        case ($urandom_range(0, 7))
            0: return (sg > 0) ? 16'h7FFF : 16'h8000;
            1: return (sg > 0) ? 16'h0001 : 16'hFFFF;
            default: return (sg > 0) ? 16'($urandom_range(1, 32767))
                                     : 16'(32'h0 - $urandom_range(1, 32768));
        endcase
    endfunction

    function automatic int random_sign();
        return ($urandom_range(0, 1) == 1) ? 1 : -1;
    endfunction

    function automatic void shape_symbol(int even_shift, int odd_shift, int sec);
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            plan[2 * i] = tracker.pm(tracker.s_bits[(i + even_shift) % SEQ_LEN])
                          * tracker.pm(tracker.c_bits[(i + sec) % SEQ_LEN]);
            plan[2 * i + 1] = tracker.pm(tracker.s_bits[(i + odd_shift) % SEQ_LEN])
                              * tracker.pm(tracker.c_bits[(i + sec + 3) % SEQ_LEN])
                              * tracker.pm(tracker.z_bits[(i + even_shift % 8) % SEQ_LEN]);
        end
    endfunction

    function automatic void table_symbol(int grp, bit late, int sec);
        if (late)
            shape_symbol(tracker.group_m1[grp], tracker.group_m0[grp], sec);
        else
            shape_symbol(tracker.group_m0[grp], tracker.group_m1[grp], sec);
    endfunction

    function automatic void spoil(int count);
        int idx;
        for (int k = 0; k < count; k++)
        begin
            idx = $urandom_range(0, NUM_SC - 1);
            if ($urandom_range(0, 1) == 1)
                plan[idx] = -plan[idx];
            else
                plan[idx] = 0;
        end
    endfunction

    function automatic void noise_symbol();
        foreach (plan[i])
            plan[i] = ($urandom_range(0, 4) == 0) ? 0 : random_sign();
    endfunction

    task automatic send_word(input logic [SAMPLE_W-1:0] value);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_sample(value);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_symbol();
        foreach (plan[i])
            send_word(word_for(plan[i]));
        symbols_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_detections.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        if (idx == REG_SECTOR)
            tracker.sector = int'(data[SECTOR_W-1:0]);
        else
            tracker.threshold = int'(data);
    endtask

    task automatic apply_setting(input int sec, input int thr);
        logic [CFG_W-1:0] sector_word;
        sector_word = {3'($urandom_range(0, 7)), 2'(sec)};
        if ($urandom_range(0, 1) == 1)
        begin
            write_reg(REG_SECTOR, sector_word);
            write_reg(REG_THRESH, CFG_W'(thr));
        end
        else
        begin
            write_reg(REG_THRESH, CFG_W'(thr));
            write_reg(REG_SECTOR, sector_word);
        end
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 31;
            2: return $urandom_range(22, 31);
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    task automatic random_symbol();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            table_symbol($urandom_range(0, NUM_GROUPS - 1), $urandom_range(0, 1),
                         tracker.sector);
            spoil($urandom_range(0, 3));
        end
        else if (kind < 65)
            table_symbol($urandom_range(0, NUM_GROUPS - 1), $urandom_range(0, 1),
                         $urandom_range(0, 3));
        else if (kind < 80)
        begin
            shape_symbol($urandom_range(0, SEQ_LEN - 1), $urandom_range(0, SEQ_LEN - 1),
                         tracker.sector);
            spoil($urandom_range(0, 2));
        end
        else if (kind < 90)
            noise_symbol();
        else
        begin
            table_symbol($urandom_range(0, NUM_GROUPS - 1), $urandom_range(0, 1),
                         tracker.sector);
            for (int i = 0; i < SEQ_LEN; i++)
                plan[2 * i + 1] = random_sign();
        end
        send_symbol();
    endtask

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] corner_words[8];
        corner_words = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                         16'h0000, 16'h5555, 16'hAAAA, 16'h7FFF};
        in_valid  = 1'b0;
        sample    = '0;
        cfg_write = 1'b0;
        cfg_index = REG_SECTOR;
        cfg_data  = '0;
        rst_n     = 1'b0;
        tracker   = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A zero symbol has no positive correlation; its peaks and shifts stay zero.
        foreach (plan[i])
            plan[i] = 0;
        send_symbol();
        noise_symbol();
        foreach (plan[i])
            send_word((i < 8) ? corner_words[i] : word_for(plan[i]));
        symbols_sent++;
        table_symbol(0, 1'b0, 0);
        send_symbol();

        // Sector three with a zero threshold: an empty symbol turns into a missing pair.
        drain();
        apply_setting(3, 0);
        foreach (plan[i])
            plan[i] = 0;
        send_symbol();
        table_symbol(NUM_GROUPS - 1, 1'b1, 3);
        send_symbol();
        shape_symbol(5, 29, 3);
        send_symbol();

        drain();
        apply_setting(2, 31);
        table_symbol(77, 1'b0, 2);
        spoil(1);
        send_symbol();
        table_symbol(100, 1'b1, 2);
        send_symbol();

        while (words_sent < RANDOM_WORDS || symbols_sent < MIN_SYMBOLS)
        begin
            drain();
            apply_setting($urandom_range(0, 3), pick_threshold());
            repeat ($urandom_range(3, 7))
                if (words_sent < RANDOM_WORDS)
                    random_symbol();
        end

        drain();
        calm = 1'b1;
        apply_setting($urandom_range(0, 2), $urandom_range(20, 31));
        repeat (4)
            random_symbol();
        in_valid <= 1'b0;

        while (tracker.pending_detections.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_detections.size() == 0)
            $display("sss_cell_id_detector verification clean");
        else
            $display("sss_cell_id_detector verification failed");
        $finish;
    end

endmodule
